[rtl/afc_pkg.sv]
// shared constants and types for the box frustum cull core
package afc_pkg;

	localparam int NUM_PLANE_REGS = 6;
	localparam int CFG_INDEX_BITS = 3;
	localparam int PLANE_BITS     = 64;
	localparam int AXES           = 3;
	localparam int NRM_BITS       = 14;
	localparam int OFS_BITS       = 22;
	localparam int OFS_LSB        = AXES * NRM_BITS;
	localparam int OUT_BYTES_W    = 8;

	typedef logic [PLANE_BITS-1:0] plane_t;

	// stage load enables handed to each plane unit
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} afc_stage_en_t;

endpackage

[rtl/afc_plane.sv]
// one frustum plane: products, sums and the inside test for a box
module afc_plane
	import afc_pkg::*;
#(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  afc_stage_en_t               en,
	input  logic signed [COORD_BITS:0]  sum_s1 [AXES],
	input  logic [COORD_BITS-1:0]       span_s1 [AXES],
	input  plane_t                      plane,
	output logic                        in_front
);

	localparam int SUM_W  = COORD_BITS + 1;
	localparam int PROD_W = SUM_W + NRM_BITS;
	localparam int EXTP_W = COORD_BITS + NRM_BITS;
	localparam int DIST_W = COORD_BITS + 18;
	localparam int EXT_W  = COORD_BITS + 16;

	logic signed [NRM_BITS-1:0] nrm [AXES];
	logic [NRM_BITS-1:0]        nrm_mag [AXES];
	logic signed [OFS_BITS-1:0] ofs;

	logic signed [PROD_W-1:0]   dprod_s2 [AXES];
	logic [EXTP_W-1:0]          eprod_s2 [AXES];
	logic signed [DIST_W-1:0]   dist_s3;
	logic [EXT_W-1:0]           ext_s3;
	logic signed [DIST_W-1:0]   total;

	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			nrm[k]     = $signed(plane[k*NRM_BITS +: NRM_BITS]);
			nrm_mag[k] = nrm[k][NRM_BITS-1] ? NRM_BITS'(-nrm[k]) : NRM_BITS'(nrm[k]);
		end
		ofs = $signed(plane[OFS_LSB +: OFS_BITS]);
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			for (int k = 0; k < AXES; k++) begin
				dprod_s2[k] <= PROD_W'(nrm[k]) * PROD_W'(sum_s1[k]);
				eprod_s2[k] <= EXTP_W'(nrm_mag[k]) * EXTP_W'(span_s1[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			dist_s3 <= DIST_W'(dprod_s2[0]) + DIST_W'(dprod_s2[1]) + DIST_W'(dprod_s2[2])
				+ (DIST_W'(ofs) <<< 1);
			ext_s3  <= EXT_W'(eprod_s2[0]) + EXT_W'(eprod_s2[1]) + EXT_W'(eprod_s2[2]);
		end
	end

	// culled when dist < -ext
	assign total    = dist_s3 + $signed(DIST_W'({1'b0, ext_s3}));
	assign in_front = ~total[DIST_W-1];

endmodule

[rtl/aabb_frustum_cull_core.sv]
// top level of the axis-aligned box frustum cull core
// Tests one box per clock against up to six planes and returns visible = 0 when the box lies
// wholly behind some plane. There are four register stages that an accepted item passes through
// in order: corner sum and span, per-plane multiplies (three signed and three magnitude products
// per plane), per-plane sums, then the plane compares and their AND into the output register.
// Each stage holds its own valid bit and advances into a free slot, so bubbles close up under
// backpressure and a new box is taken every cycle while the output is being consumed.
// Plane registers are written through cfg_we/cfg_index/cfg_data; index 6 and 7 are ignored.
module aabb_frustum_cull_core
	import afc_pkg::*;
#(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z, zero pad
	input  logic [((AXES*2*COORD_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// visible, zero pad
	output logic [OUT_BYTES_W-1:0]                m_tdata,
	input  logic                                  cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]             cfg_index,
	input  logic [PLANE_BITS-1:0]                 cfg_data
);

	localparam int SUM_W = COORD_BITS + 1;

	plane_t                    planes_q [NUM_PLANE_REGS];

	logic                      valid_s1, valid_s2, valid_s3, valid_s4;
	logic                      adv_s1, adv_s2, adv_s3, adv_s4;
	afc_stage_en_t             stage_en;

	logic signed [COORD_BITS-1:0] lo [AXES];
	logic signed [COORD_BITS-1:0] hi [AXES];
	logic signed [SUM_W-1:0]      diff [AXES];

	logic signed [SUM_W-1:0]      sum_s1 [AXES];
	logic [COORD_BITS-1:0]        span_s1 [AXES];
	logic [PLANE_COUNT-1:0]       in_front;
	logic                         visible_s4;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANE_REGS; i++) begin
				planes_q[i] <= '0;
			end
		end else if (cfg_we && (int'(cfg_index) < NUM_PLANE_REGS)) begin
			planes_q[cfg_index] <= cfg_data;
		end
	end

	// stage advance chain
	assign adv_s4   = !valid_s4 || m_tready;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	assign stage_en.en_s2 = adv_s2 && valid_s1;
	assign stage_en.en_s3 = adv_s3 && valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= s_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	// corner sum and span
	always_comb begin
		for (int k = 0; k < AXES; k++) begin
			lo[k]   = $signed(s_tdata[k*COORD_BITS +: COORD_BITS]);
			hi[k]   = $signed(s_tdata[(k+AXES)*COORD_BITS +: COORD_BITS]);
			diff[k] = SUM_W'(hi[k]) - SUM_W'(lo[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && adv_s1) begin
			for (int k = 0; k < AXES; k++) begin
				sum_s1[k]  <= SUM_W'(lo[k]) + SUM_W'(hi[k]);
				span_s1[k] <= diff[k][SUM_W-1] ? COORD_BITS'(-diff[k])
				                               : COORD_BITS'(diff[k]);
			end
		end
	end

	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_plane
		afc_plane #(
			.COORD_BITS(COORD_BITS)
		) u_plane (
			.clk     (clk),
			.en      (stage_en),
			.sum_s1  (sum_s1),
			.span_s1 (span_s1),
			.plane   (planes_q[p]),
			.in_front(in_front[p])
		);
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && valid_s3) begin
			visible_s4 <= &in_front;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = {{(OUT_BYTES_W-1){1'b0}}, visible_s4};

	// an accepted item lands in the first stage
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("accepted item missing from stage 1");

	// a new result only comes out of an occupied sum stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s3))
		else $error("result appeared without an item in stage 3");

	// a blocked stage 1 keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s2 |=> valid_s1 && $stable(sum_s1[0]) && $stable(span_s1[0]))
		else $error("stage 1 item changed while stalled");

	// input side stalls only when every stage is full and the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 && !m_tready)
		else $error("input stalled with a free stage");

endmodule
